/* rtl/core/hid_keyboard_report_builder_macros.svh */
// Assertion macros shared by the report builder RTL.
`ifndef HID_KEYBOARD_REPORT_BUILDER_MACROS_SVH
`define HID_KEYBOARD_REPORT_BUILDER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define HKRB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("report builder check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define HKRB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("report builder check failed");

`endif

/* rtl/core/hkrb_pkg.sv */
package hkrb_pkg;

    localparam int BOOT_SLOTS = 6;
    localparam int KEY_BYTES  = 26;
    localparam int ADDR_W     = $clog2(KEY_BYTES);

    typedef logic [ADDR_W-1:0] addr_t;

    localparam logic [2:0] ACT_KEY   = 3'd0;
    localparam logic [2:0] ACT_CONS  = 3'd1;
    localparam logic [2:0] ACT_SYS   = 3'd2;
    localparam logic [2:0] ACT_FLUSH = 3'd3;
    localparam logic [2:0] ACT_READ  = 3'd4;
    localparam logic [2:0] ACT_NONE  = 3'd7;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_IGN  = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;
    localparam logic [1:0] STAT_BAD  = 2'd3;

    localparam logic [4:0] CHG_MOD  = 5'h01;
    localparam logic [4:0] CHG_MAIN = 5'h02;
    localparam logic [4:0] CHG_SEC  = 5'h04;
    localparam logic [4:0] CHG_CONS = 5'h08;
    localparam logic [4:0] CHG_SYS  = 5'h10;

    localparam logic [7:0] EV_PRESS   = 8'd1;
    localparam logic [7:0] EV_HOLD    = 8'd2;
    localparam logic [7:0] EV_RELEASE = 8'd3;
    localparam logic [7:0] EV_NOP     = 8'hFF;
    localparam logic [7:0] KIND_DIG   = 8'd0;

    localparam logic [7:0] BOOT_MAX_KEY = 8'd104;
    localparam logic [7:0] MAIN_LO      = 8'd4;
    localparam logic [7:0] MAIN_HI      = 8'd164;
    localparam logic [7:0] SEC_LO       = 8'd176;
    localparam logic [7:0] SEC_HI       = 8'd221;
    localparam logic [7:0] SEC_OFFSET   = 8'd15;
    localparam logic [7:0] MOD_LAST     = 8'hE7;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SWEEP
    } state_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  event_state;
        logic [7:0]  event_kind;
        logic [15:0] code;
        logic [4:0]  read_index;
    } item_t;

    typedef struct packed {
        logic [7:0]  key_byte;
        logic [7:0]  modifier_bits;
        logic [4:0]  change_flags;
        logic [7:0]  key_count;
        logic [15:0] consumer_code;
        logic [7:0]  system_code;
        logic [1:0]  status;
    } result_t;

    typedef struct packed {
        logic [7:0]  modifier;
        logic [4:0]  change;
        logic [7:0]  count;
        logic [15:0] consumer;
        logic [7:0]  system;
    } regs_t;

    typedef struct packed {
        regs_t      regs;
        logic       mem_we;
        addr_t      mem_addr;
        logic [7:0] mem_data;
        result_t    res;
        logic       sweep;
    } upd_t;

    // NKRO bitmap bit for a key code in the main or secondary range.
    function automatic logic [7:0] nkro_bit(logic [7:0] key);
        logic [7:0] b;
        if (key >= SEC_LO) begin
            b = key - SEC_OFFSET;
        end
        else begin
            b = key - MAIN_LO;
        end
        return b;
    endfunction

    // Store byte the item needs, so the read can start as the item is taken.
    function automatic addr_t read_addr(item_t it, logic mode, logic [7:0] cnt);
        logic [7:0] b;
        addr_t a;
        b = nkro_bit(it.code[7:0]);
        a = '0;
        if (it.action == ACT_READ) begin
            if (32'(it.read_index) < KEY_BYTES) begin
                a = it.read_index[ADDR_W-1:0];
            end
        end
        else if (mode) begin
            if (32'(b[7:3]) < KEY_BYTES) begin
                a = b[ADDR_W+2:3];
            end
        end
        else if (32'(cnt) < KEY_BYTES) begin
            a = cnt[ADDR_W-1:0];
        end
        return a;
    endfunction

endpackage

/* rtl/core/hkrb_key_store.sv */
module hkrb_key_store
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  hkrb_pkg::addr_t      rd_addr,
    output logic [7:0]           rd_data,
    input  logic                 wr_en,
    input  hkrb_pkg::addr_t      wr_addr,
    input  logic [7:0]           wr_data
);

    logic [7:0]                     mem [hkrb_pkg::KEY_BYTES];
    logic [hkrb_pkg::KEY_BYTES-1:0] valid_reg;
    logic [7:0]                     rd_q_reg;
    logic                           rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // An entry never written since reset reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_q_reg : 8'h00;

endmodule

/* rtl/core/hkrb_event_unit.sv */
module hkrb_event_unit
(
    input  hkrb_pkg::item_t  item,
    input  logic             mode,
    input  hkrb_pkg::regs_t  regs,
    input  logic [7:0]       rd_data,
    output hkrb_pkg::upd_t   upd
);

    logic [2:0]  act;
    logic [7:0]  key;
    logic [7:0]  st;
    logic [7:0]  kind;
    logic        press_rel;
    logic        dig_rel;
    logic        press;
    logic        flush;
    logic [7:0]  bitn;
    logic [7:0]  bmask;
    logic [7:0]  mmask;
    logic [1:0]  status;
    logic [7:0]  key_byte;
    logic [4:0]  chg_flag;
    hkrb_pkg::regs_t nx;

    always_comb
    begin
        st        = item.event_state;
        kind      = item.event_kind;
        key       = item.code[7:0];
        act       = item.action;
        if (act <= hkrb_pkg::ACT_SYS && st == hkrb_pkg::EV_NOP && kind == hkrb_pkg::EV_NOP)
        begin
            act = hkrb_pkg::ACT_NONE;
        end
        press_rel = (st == hkrb_pkg::EV_PRESS) || (st == hkrb_pkg::EV_RELEASE);
        dig_rel   = (kind == hkrb_pkg::KIND_DIG) && (st == hkrb_pkg::EV_RELEASE);
        press     = (kind == hkrb_pkg::KIND_DIG) && (st == hkrb_pkg::EV_PRESS);
        bitn      = hkrb_pkg::nkro_bit(key);
        bmask     = 8'h01 << bitn[2:0];
        mmask     = 8'h01 << key[2:0];
        chg_flag  = (act == hkrb_pkg::ACT_CONS) ? hkrb_pkg::CHG_CONS : hkrb_pkg::CHG_SYS;
        nx        = regs;
        status    = hkrb_pkg::STAT_IGN;
        key_byte  = 8'h00;
        flush     = 1'b0;
        upd.mem_we   = 1'b0;
        upd.mem_addr = '0;
        upd.mem_data = 8'h00;
        upd.sweep    = 1'b0;

        unique case (act)
            hkrb_pkg::ACT_KEY:
            begin
                if (!mode)
                begin
                    if (press_rel)
                    begin
                        nx.change = hkrb_pkg::CHG_MAIN;
                    end
                    if (dig_rel)
                    begin
                        status = hkrb_pkg::STAT_IGN;
                    end
                    else if (key[7:5] == 3'b111)
                    begin
                        if (key > hkrb_pkg::MOD_LAST)
                        begin
                            status = hkrb_pkg::STAT_BAD;
                        end
                        else
                        begin
                            nx.modifier = regs.modifier | mmask;
                            status      = hkrb_pkg::STAT_OK;
                        end
                    end
                    else if (32'(regs.count) >= hkrb_pkg::BOOT_SLOTS)
                    begin
                        status = hkrb_pkg::STAT_FULL;
                    end
                    else if (key > hkrb_pkg::BOOT_MAX_KEY)
                    begin
                        status = hkrb_pkg::STAT_BAD;
                    end
                    else
                    begin
                        upd.mem_we   = 1'b1;
                        upd.mem_addr = regs.count[hkrb_pkg::ADDR_W-1:0];
                        upd.mem_data = key;
                        nx.count     = regs.count + 8'd1;
                        status       = hkrb_pkg::STAT_OK;
                    end
                end
                else if (kind == hkrb_pkg::KIND_DIG && st == hkrb_pkg::EV_HOLD)
                begin
                    status = hkrb_pkg::STAT_IGN;
                end
                else if (key[7:5] == 3'b111)
                begin
                    nx.change = regs.change | hkrb_pkg::CHG_MOD;
                    if (key > hkrb_pkg::MOD_LAST)
                    begin
                        status = hkrb_pkg::STAT_BAD;
                    end
                    else
                    begin
                        nx.modifier = press ? (regs.modifier | mmask)
                                            : (regs.modifier & ~mmask);
                        status      = hkrb_pkg::STAT_OK;
                    end
                end
                else if ((key >= hkrb_pkg::MAIN_LO && key <= hkrb_pkg::MAIN_HI) ||
                         (key >= hkrb_pkg::SEC_LO && key <= hkrb_pkg::SEC_HI))
                begin
                    nx.change    = regs.change | ((key >= hkrb_pkg::SEC_LO) ?
                                   hkrb_pkg::CHG_SEC : hkrb_pkg::CHG_MAIN);
                    upd.mem_we   = 1'b1;
                    upd.mem_addr = bitn[hkrb_pkg::ADDR_W+2:3];
                    upd.mem_data = press ? (rd_data | bmask) : (rd_data & ~bmask);
                    nx.count     = regs.count + 8'd1;
                    status       = hkrb_pkg::STAT_OK;
                end
                else
                begin
                    status = hkrb_pkg::STAT_BAD;
                end
            end
            hkrb_pkg::ACT_CONS, hkrb_pkg::ACT_SYS:
            begin
                if (!mode)
                begin
                    status = hkrb_pkg::STAT_IGN;
                end
                else
                begin
                    if (press_rel)
                    begin
                        nx.change = regs.change | chg_flag;
                    end
                    if (dig_rel)
                    begin
                        status = hkrb_pkg::STAT_IGN;
                    end
                    else
                    begin
                        if (act == hkrb_pkg::ACT_CONS)
                        begin
                            nx.consumer = item.code;
                        end
                        else
                        begin
                            nx.system = key;
                        end
                        status = hkrb_pkg::STAT_OK;
                    end
                end
            end
            hkrb_pkg::ACT_FLUSH:
            begin
                flush       = 1'b1;
                // Unused boot slots are zeroed by a sweep after this step.
                upd.sweep   = !mode && (32'(regs.count) < hkrb_pkg::BOOT_SLOTS);
                nx.modifier = 8'h00;
                nx.count    = 8'h00;
                nx.change   = 5'h00;
                status      = hkrb_pkg::STAT_OK;
            end
            hkrb_pkg::ACT_READ:
            begin
                if (32'(item.read_index) < hkrb_pkg::KEY_BYTES)
                begin
                    key_byte = rd_data;
                end
                status = hkrb_pkg::STAT_OK;
            end
            default:
            begin
                status = hkrb_pkg::STAT_IGN;
            end
        endcase

        upd.regs              = nx;
        upd.res.key_byte      = key_byte;
        upd.res.modifier_bits = flush ? regs.modifier : nx.modifier;
        upd.res.change_flags  = flush ? regs.change : nx.change;
        upd.res.key_count     = flush ? regs.count : nx.count;
        upd.res.consumer_code = nx.consumer;
        upd.res.system_code   = nx.system;
        upd.res.status        = status;
    end

endmodule

/* rtl/core/hid_keyboard_report_builder.sv */
// An accepted word moves from S_IDLE to S_EXEC, where its result is registered once
// no earlier result is left waiting; the store read starts at acceptance, and no
// new word is taken before S_IDLE; a boot-mode flush zeroes unused slots in S_SWEEP.
// Reset clears the state registers and the store valid bits, so the store reads
// as all zero at once with no clearing pass.
`include "hid_keyboard_report_builder_macros.svh"

module hid_keyboard_report_builder
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data,
    input  logic              item_valid,
    output logic              item_ready,
    input  hkrb_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output hkrb_pkg::result_t result
);

    hkrb_pkg::state_t  state_reg;
    hkrb_pkg::state_t  state_next;
    hkrb_pkg::regs_t   regs_reg;
    hkrb_pkg::item_t   item_reg;
    hkrb_pkg::result_t res_reg;
    logic              res_valid_reg;
    logic              mode_reg;
    hkrb_pkg::addr_t   sweep_ptr_reg;
    hkrb_pkg::addr_t   sweep_ptr_next;

    hkrb_pkg::upd_t    upd;
    logic              load;
    logic              rd_en;
    hkrb_pkg::addr_t   rd_addr;
    logic [7:0]        rd_data;
    logic              wr_en;
    hkrb_pkg::addr_t   wr_addr;
    logic [7:0]        wr_data;

    assign cfg_ready    = 1'b1;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign rd_addr      = hkrb_pkg::read_addr(item, mode_reg, regs_reg.count);

    hkrb_key_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    hkrb_event_unit u_event
    (
        .item    (item_reg),
        .mode    (mode_reg),
        .regs    (regs_reg),
        .rd_data (rd_data),
        .upd     (upd)
    );

    always_comb
    begin
        state_next     = state_reg;
        sweep_ptr_next = sweep_ptr_reg;
        item_ready     = 1'b0;
        rd_en          = 1'b0;
        load           = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = upd.mem_addr;
        wr_data        = upd.mem_data;
        unique case (state_reg)
            hkrb_pkg::S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    rd_en      = 1'b1;
                    state_next = hkrb_pkg::S_EXEC;
                end
            end
            hkrb_pkg::S_EXEC:
            begin
                // Holds here while the previous result still waits.
                if (!res_valid_reg || result_ready)
                begin
                    load  = 1'b1;
                    wr_en = upd.mem_we;
                    if (upd.sweep)
                    begin
                        sweep_ptr_next = regs_reg.count[hkrb_pkg::ADDR_W-1:0];
                        state_next     = hkrb_pkg::S_SWEEP;
                    end
                    else
                    begin
                        state_next = hkrb_pkg::S_IDLE;
                    end
                end
            end
            hkrb_pkg::S_SWEEP:
            begin
                wr_en          = 1'b1;
                wr_addr        = sweep_ptr_reg;
                wr_data        = 8'h00;
                sweep_ptr_next = sweep_ptr_reg + hkrb_pkg::addr_t'(1);
                if (sweep_ptr_reg == hkrb_pkg::addr_t'(hkrb_pkg::BOOT_SLOTS - 1))
                begin
                    state_next = hkrb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = hkrb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hkrb_pkg::S_IDLE;
            regs_reg      <= '0;
            res_valid_reg <= 1'b0;
            mode_reg      <= 1'b0;
            sweep_ptr_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_ptr_reg <= sweep_ptr_next;
            if (cfg_valid)
            begin
                mode_reg <= cfg_data;
            end
            if (load)
            begin
                regs_reg      <= upd.regs;
                res_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        if (load)
        begin
            res_reg <= upd.res;
        end
    end

    `HKRB_ASSERT_NEXT(a_accept_exec, item_valid && item_ready, state_reg == hkrb_pkg::S_EXEC)
    `HKRB_ASSERT_NEXT(a_load_offers, load, result_valid)
    `HKRB_ASSERT_IMP(a_sweep_range, state_reg == hkrb_pkg::S_SWEEP, sweep_ptr_reg < hkrb_pkg::addr_t'(hkrb_pkg::BOOT_SLOTS))
    `HKRB_ASSERT_IMP(a_write_busy, wr_en, state_reg == hkrb_pkg::S_EXEC || state_reg == hkrb_pkg::S_SWEEP)

endmodule
